FILE: hdl/german_word_clock_phrase_macros.svh
// ----------------------------------------------------------------------------
// German word clock phrase - assertion macros
// Shared helpers for writing clocked assertions in the checker.
// ----------------------------------------------------------------------------
`ifndef GERMAN_WORD_CLOCK_PHRASE_MACROS_SVH
`define GERMAN_WORD_CLOCK_PHRASE_MACROS_SVH

// Assertion sampled on the rising clock, off while reset is active.
`define WCP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, for properties that also hold while reset is active.
`define WCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/wcp_pkg.sv
// ----------------------------------------------------------------------------
// German word clock phrase - package
// Word codes, payload structs and the phrase descriptor shared by all modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wcp_pkg;

    typedef logic [4:0] word_code_t;

    localparam word_code_t W_ES          = 5'd0;
    localparam word_code_t W_IST         = 5'd1;
    localparam word_code_t W_UHR         = 5'd2;
    localparam word_code_t W_VIERTEL     = 5'd3;
    localparam word_code_t W_NACH        = 5'd4;
    localparam word_code_t W_VOR         = 5'd5;
    localparam word_code_t W_HALB        = 5'd6;
    localparam word_code_t W_DREIVIERTEL = 5'd7;
    localparam word_code_t W_FUENF       = 5'd8;
    localparam word_code_t W_ZEHN        = 5'd9;
    localparam word_code_t W_ZWANZIG     = 5'd10;
    localparam word_code_t W_EIN         = 5'd11;
    localparam word_code_t W_HOUR_BASE   = 5'd11;
    localparam word_code_t W_DOT_BASE    = 5'd23;
    localparam word_code_t W_ERROR       = 5'd28;

    localparam logic [5:0] MINUTE_MAX    = 6'd59;
    localparam logic [4:0] HALF_DAY      = 5'd12;
    localparam logic [4:0] FULL_DAY      = 5'd24;
    // minute / 5 == (minute * 13) >> 6 for every minute from 0 to 59
    localparam logic [3:0] DIV5_MUL      = 4'd13;
    localparam int         DIV5_SHIFT    = 6;

    localparam int PHRASE_MAX = 6;

    typedef struct packed {
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
    } wcp_in_t;

    typedef struct packed {
        logic [4:0] word_code;
        logic       last_word;
    } wcp_out_t;

    // One classified time: the phrase words, their count and the dot count.
    typedef struct packed {
        word_code_t [PHRASE_MAX-1:0] words;
        logic [2:0]                  plen;
        logic [2:0]                  dots;
    } wcp_desc_t;

    function automatic word_code_t hour_word(input logic [3:0] hour);
        hour_word = W_HOUR_BASE + word_code_t'(hour);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/wcp_front.sv
// ----------------------------------------------------------------------------
// German word clock phrase - front end
// Classifies one time of day into a phrase descriptor for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wcp_front
    import wcp_pkg::*;
(
    input  wire logic      regional,
    input  wire wcp_in_t   time_in,
    output wcp_desc_t      desc
);

    logic [4:0] hour_mod;
    logic [3:0] cur_hour;
    logic [3:0] next_hour;
    logic [9:0] div_prod;
    logic [3:0] quot;
    logic [5:0] rounded;
    logic [5:0] dot_diff;

    always_comb begin
        if (time_in.hour_of_day >= FULL_DAY) begin
            hour_mod = time_in.hour_of_day - FULL_DAY;
        end else if (time_in.hour_of_day >= HALF_DAY) begin
            hour_mod = time_in.hour_of_day - HALF_DAY;
        end else begin
            hour_mod = time_in.hour_of_day;
        end
        cur_hour  = (hour_mod == 5'd0) ? HALF_DAY[3:0] : hour_mod[3:0];
        next_hour = (cur_hour == HALF_DAY[3:0]) ? 4'd1 : cur_hour + 4'd1;

        div_prod = 10'(time_in.minute_of_hour) * 10'(DIV5_MUL);
        quot     = div_prod[DIV5_SHIFT +: 4];
        rounded  = 6'({quot, 2'b00}) + 6'(quot);
        dot_diff = time_in.minute_of_hour - rounded;

        desc          = '0;
        desc.words[0] = W_ES;
        desc.words[1] = W_IST;
        desc.plen     = 3'd5;
        desc.dots     = dot_diff[2:0];

        unique case (quot)
            4'd0: begin
                desc.words[2] = (cur_hour == 4'd1) ? W_EIN : hour_word(cur_hour);
                desc.words[3] = W_UHR;
                desc.plen     = 3'd4;
            end
            4'd1: begin
                desc.words[2] = W_FUENF;
                desc.words[3] = W_NACH;
                desc.words[4] = hour_word(cur_hour);
            end
            4'd2: begin
                desc.words[2] = W_ZEHN;
                desc.words[3] = W_NACH;
                desc.words[4] = hour_word(cur_hour);
            end
            4'd3: begin
                desc.words[2] = W_VIERTEL;
                if (regional) begin
                    desc.words[3] = hour_word(next_hour);
                    desc.plen     = 3'd4;
                end else begin
                    desc.words[3] = W_NACH;
                    desc.words[4] = hour_word(cur_hour);
                end
            end
            4'd4: begin
                desc.words[2] = W_ZWANZIG;
                desc.words[3] = W_NACH;
                desc.words[4] = hour_word(cur_hour);
            end
            4'd5: begin
                desc.words[2] = W_FUENF;
                desc.words[3] = W_VOR;
                desc.words[4] = W_HALB;
                desc.words[5] = hour_word(next_hour);
                desc.plen     = 3'd6;
            end
            4'd6: begin
                desc.words[2] = W_HALB;
                desc.words[3] = hour_word(next_hour);
                desc.plen     = 3'd4;
            end
            4'd7: begin
                desc.words[2] = W_FUENF;
                desc.words[3] = W_NACH;
                desc.words[4] = W_HALB;
                desc.words[5] = hour_word(next_hour);
                desc.plen     = 3'd6;
            end
            4'd8: begin
                desc.words[2] = W_ZWANZIG;
                desc.words[3] = W_VOR;
                desc.words[4] = hour_word(next_hour);
            end
            4'd9: begin
                if (regional) begin
                    desc.words[2] = W_DREIVIERTEL;
                    desc.words[3] = hour_word(next_hour);
                    desc.plen     = 3'd4;
                end else begin
                    desc.words[2] = W_VIERTEL;
                    desc.words[3] = W_VOR;
                    desc.words[4] = hour_word(next_hour);
                end
            end
            4'd10: begin
                desc.words[2] = W_ZEHN;
                desc.words[3] = W_VOR;
                desc.words[4] = hour_word(next_hour);
            end
            4'd11: begin
                desc.words[2] = W_FUENF;
                desc.words[3] = W_VOR;
                desc.words[4] = hour_word(next_hour);
            end
            default: begin
                desc.words[0] = W_ERROR;
                desc.plen     = 3'd1;
                desc.dots     = 3'd0;
            end
        endcase

        // Out-of-range minutes give a lone error word.
        if (time_in.minute_of_hour > MINUTE_MAX) begin
            desc.words[0] = W_ERROR;
            desc.plen     = 3'd1;
            desc.dots     = 3'd0;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wcp_queue.sv
// ----------------------------------------------------------------------------
// German word clock phrase - descriptor queue
// Two-entry queue between the classifier and the word sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module wcp_queue
    import wcp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire wcp_desc_t push_desc,
    output logic           full,
    input  wire logic      pop,
    output logic           head_valid,
    output wcp_desc_t      head_desc
);

    wcp_desc_t  entries_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb begin
        full        = (count_reg == 2'd2);
        head_valid  = (count_reg != 2'd0);
        head_desc   = entries_reg[rd_ptr_reg];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wcp_back.sv
// ----------------------------------------------------------------------------
// German word clock phrase - word sequencer
// Walks the head descriptor to the output register, one word per ready cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wcp_back
    import wcp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      head_valid,
    input  wire wcp_desc_t head_desc,
    output logic           pop,
    output logic           m_valid,
    input  wire logic      m_ready,
    output wcp_out_t       m_data
);

    logic [3:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    wcp_out_t   m_data_reg, m_data_next;
    logic       load;
    logic [3:0] total;
    logic [3:0] dot_num;
    logic       is_last;
    word_code_t cur_word;

    always_comb begin
        load    = !m_valid_reg || m_ready;
        total   = 4'(head_desc.plen) + 4'(head_desc.dots);
        is_last = (idx_reg == total - 4'd1);
        dot_num = idx_reg - 4'(head_desc.plen) + 4'd1;
        if (idx_reg < 4'(head_desc.plen)) begin
            cur_word = head_desc.words[idx_reg[2:0]];
        end else begin
            cur_word = W_DOT_BASE + word_code_t'(dot_num);
        end

        pop          = 1'b0;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = head_valid;
            if (head_valid) begin
                m_data_next.word_code = cur_word;
                m_data_next.last_word = is_last;
                pop                   = is_last;
                idx_next              = is_last ? 4'd0 : idx_reg + 4'd1;
            end
        end
        m_valid = m_valid_reg;
        m_data  = m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

FILE: hdl/german_word_clock_phrase.sv
// ----------------------------------------------------------------------------
// German word clock phrase - top level
// Turns a time of day into the word-clock phrase, one word code per word.
// ----------------------------------------------------------------------------
// Usage:
// A time arrives on the s_ channel as hours and minutes. The block answers on
// the m_ channel with one word per cycle while m_ready is high: "es", "ist",
// the five-minute phrase and up to four minute dots, with last_word set on
// the final word. A minute above 59 yields a single error word instead.
// The first word is registered in the output register after the descriptor has been queued.
// Throughput: one word per cycle while m_ready is high; a time has four to
// ten words (one for an error); the word sequencer's single output register
// sets that rate.
// The classifier feeds a two-entry descriptor queue, so new times are taken
// while the sequencer is still emitting an earlier phrase.
// When the receiver stalls, the current word holds in the output register and
// the queue fills; s_ready falls once both entries are taken.
// Reset empties the queue and the output register and sets the regional
// phrasing register back to the standard forms.
// cfg_wr_en writes cfg_wr_data into the regional phrasing register at once;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module german_word_clock_phrase
    import wcp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    cfg_wr_en,
    input  wire logic    cfg_wr_data,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire wcp_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output wcp_out_t     m_data
);

    // Regional phrasing: viertel / dreiviertel followed by the next hour.
    logic      regional_reg, regional_next;
    wcp_desc_t front_desc;
    wcp_desc_t head_desc;
    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      head_valid;

    always_comb begin
        regional_next = cfg_wr_en ? cfg_wr_data : regional_reg;
        s_ready       = !q_full;
        q_push        = s_valid && !q_full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regional_reg <= 1'b0;
        end else begin
            regional_reg <= regional_next;
        end
    end

    // Front: classify the time into a phrase descriptor.
    wcp_front u_front (
        .regional (regional_reg),
        .time_in  (s_data),
        .desc     (front_desc)
    );

    // Queue decouples classification from word emission.
    wcp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (front_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    // Back: emit the phrase one word per cycle while the receiver is ready.
    wcp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

FILE: hdl/wcp_checker.sv
// ----------------------------------------------------------------------------
// German word clock phrase - port checker
// Watches the ports for reset, phrase ordering, output stability, word codes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "german_word_clock_phrase_macros.svh"

module wcp_checker
    import wcp_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire wcp_out_t m_data
);

    // A reset leaves the block empty and ready for a new time.
    `WCP_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> s_ready && !m_valid, "not idle after reset")
    // A stalled word must not change.
    `WCP_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "word changed while stalled")
    // The error word always ends its phrase.
    `WCP_ASSERT(a_err_last, aclk, aresetn, m_valid && m_data.word_code == W_ERROR |-> m_data.last_word, "error word not last")
    // "es" is always followed at once by "ist".
    `WCP_ASSERT(a_es_ist, aclk, aresetn, m_valid && m_ready && m_data.word_code == W_ES |=> m_valid && m_data.word_code == W_IST && !m_data.last_word, "es not followed by ist")
    // No code beyond the error word ever appears.
    `WCP_ASSERT(a_code_range, aclk, aresetn, m_valid |-> m_data.word_code <= W_ERROR, "word code out of range")

endmodule

bind german_word_clock_phrase wcp_checker u_wcp_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// German word clock phrase - testbench
// Sends times of day into the phrase block and checks every word that comes
// back against a hand-written phrase or the predictor in this file. A short
// table of directed times comes first: round hours, every five-minute phrase,
// the regional quarter forms, hours past 23 and bad minutes. Random times
// follow in three idling phases, the regional setting changed between runs.
// ----------------------------------------------------------------------------

module testbench;
    import wcp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    // The limit lies well above a full run even with heavy receiver stalls,
    // so it only trips when the block hangs.
    localparam int CYCLE_LIMIT  = 300000;
    // Descriptor queue plus the longest phrase, with some margin.
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 80;
    localparam int SHOWN_MAX    = 10;

    // Up to ten hand-written words of one phrase.
    typedef word_code_t [9:0] phrase_t;

    // One row of the directed table. When n_typed is nonzero the expected
    // phrase is written out by hand in typed, right aligned, so that word k
    // of the phrase sits at typed[n_typed-1-k]. Otherwise the predictor
    // works out the phrase.
    typedef struct packed {
        logic             regional;
        wcp_in_t          stamp;
        logic [3:0]       n_typed;
        phrase_t          typed;
    } time_row_t;

    logic     aclk        = 1'b0;
    logic     aresetn     = 1'b0;
    logic     cfg_wr_en   = 1'b0;
    logic     cfg_wr_data = 1'b0;
    logic     s_valid     = 1'b0;
    logic     s_ready;
    wcp_in_t  s_data      = '0;
    logic     m_valid;
    logic     m_ready     = 1'b0;
    wcp_out_t m_data;

    // Words still owed by the block, oldest first.
    wcp_out_t  words_expected[$];
    time_row_t time_table[$];

    // Our own copy of the regional phrasing register.
    logic phrasing_regional = 1'b0;

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    german_word_clock_phrase uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Phrase predictor
    // ------------------------------------------------------------------------

    // Word code for an hour from one to twelve.
    function automatic word_code_t hour_name_code(input int hour);
        return W_HOUR_BASE + word_code_t'(hour);
    endfunction

    // Word code for a five, ten or twenty minute step.
    function automatic word_code_t five_step_code(input int minutes);
        case (minutes)
            5:       return W_FUENF;
            10:      return W_ZEHN;
            default: return W_ZWANZIG;
        endcase
    endfunction

    function automatic void expect_word(input word_code_t code);
        wcp_out_t w;
        w.word_code = code;
        w.last_word = 1'b0;
        words_expected.insert(words_expected.size(), w);
    endfunction

    // Flags the most recently queued word as the end of its phrase.
    function automatic void mark_last();
        wcp_out_t w;
        w = words_expected.pop_back();
        w.last_word = 1'b1;
        words_expected.insert(words_expected.size(), w);
    endfunction

    // Queues the whole phrase for one time of day. The hour is taken modulo
    // twelve with zero shown as twelve; from :25 on, and at :15 in the regional
    // form, the phrase names the next hour, and twelve rolls over to one.
    function automatic void predict_phrase_words(input wcp_in_t stamp, input logic regional);
        int minute, cur, nxt, disp, rounded, k;
        minute = int'(stamp.minute_of_hour);
        if (minute > MINUTE_MAX) begin
            // A bad minute gives the error word alone, no "es ist", no dots.
            expect_word(W_ERROR);
        end else begin
            cur = int'(stamp.hour_of_day) % 12;
            if (cur == 0) cur = 12;
            nxt     = cur % 12 + 1;
            disp    = (minute >= 25) ? nxt : cur;
            rounded = minute / 5 * 5;
            expect_word(W_ES);
            expect_word(W_IST);
            case (rounded)
                0: begin
                    // One o'clock reads "ein uhr", not "eins uhr".
                    expect_word(disp == 1 ? W_EIN : hour_name_code(disp));
                    expect_word(W_UHR);
                end
                15: begin
                    expect_word(W_VIERTEL);
                    if (regional) begin
                        expect_word(hour_name_code(nxt));
                    end else begin
                        expect_word(W_NACH);
                        expect_word(hour_name_code(cur));
                    end
                end
                25: begin
                    expect_word(W_FUENF);
                    expect_word(W_VOR);
                    expect_word(W_HALB);
                    expect_word(hour_name_code(disp));
                end
                30: begin
                    expect_word(W_HALB);
                    expect_word(hour_name_code(disp));
                end
                35: begin
                    expect_word(W_FUENF);
                    expect_word(W_NACH);
                    expect_word(W_HALB);
                    expect_word(hour_name_code(disp));
                end
                45: begin
                    if (regional) begin
                        expect_word(W_DREIVIERTEL);
                    end else begin
                        expect_word(W_VIERTEL);
                        expect_word(W_VOR);
                    end
                    expect_word(hour_name_code(disp));
                end
                default: begin
                    if (rounded <= 20) begin
                        expect_word(five_step_code(rounded));
                        expect_word(W_NACH);
                        expect_word(hour_name_code(cur));
                    end else begin
                        expect_word(five_step_code(60 - rounded));
                        expect_word(W_VOR);
                        expect_word(hour_name_code(disp));
                    end
                end
            endcase
            // One dot per minute past the five-minute mark.
            for (k = 1; k <= minute - rounded; k++) begin
                expect_word(W_DOT_BASE + word_code_t'(k));
            end
        end
        mark_last();
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Mostly legal times; now and then an hour past 23 or a minute past 59.
    function automatic wcp_in_t random_time();
        wcp_in_t stamp;
        if ($urandom_range(99) < 88) begin
            stamp.hour_of_day = 5'($urandom_range(23));
        end else begin
            stamp.hour_of_day = 5'($urandom_range(31, 24));
        end
        if ($urandom_range(99) < 92) begin
            stamp.minute_of_hour = 6'($urandom_range(59));
        end else begin
            stamp.minute_of_hour = 6'($urandom_range(63, 60));
        end
        return stamp;
    endfunction

    function automatic void add_row(input logic regional, input logic [4:0] hour,
                                    input logic [5:0] minute, input int n_typed,
                                    input phrase_t typed);
        time_row_t row;
        row.regional              = regional;
        row.stamp.hour_of_day     = hour;
        row.stamp.minute_of_hour  = minute;
        row.n_typed               = 4'(n_typed);
        row.typed                 = typed;
        time_table.insert(time_table.size(), row);
    endfunction

    // Offers one time on the input channel and queues its phrase the moment
    // the block takes it. Every task here starts and ends in the time step of
    // a rising edge, so s_valid gets exactly one assignment per step: it stays
    // high straight into the next time when the sender does not idle.
    task automatic offer_time(input wcp_in_t stamp, input int n_typed,
                              input phrase_t typed);
        int k;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= stamp;
        do @(posedge aclk); while (!s_ready);
        if (n_typed == 0) begin
            predict_phrase_words(stamp, phrasing_regional);
        end else begin
            for (k = n_typed - 1; k >= 0; k--) begin
                expect_word(typed[k]);
            end
            mark_last();
        end
    endtask

    // Stops sending and waits until every owed word has come out, then gives
    // the block time to settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (words_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // The register is only written while the block has nothing in flight.
    task automatic set_phrasing(input logic regional);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= regional;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        phrasing_regional = regional;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, long hold-offs on request, and the
    // comparison of every accepted word with the oldest expected one.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : receiver
        wcp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (words_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_MAX) begin
                    $display("unexpected word: code %0d last %0b",
                             m_data.word_code, m_data.last_word);
                end
            end else begin
                want = words_expected.pop_front();
                if (m_data.word_code !== want.word_code ||
                    m_data.last_word !== want.last_word) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_MAX) begin
                        $display("word mismatch: expected code %0d last %0b, got code %0d last %0b",
                                 want.word_code, want.last_word,
                                 m_data.word_code, m_data.last_word);
                    end
                end
            end
        end

        // A hold-off keeps m_ready low for a long stretch so that the
        // descriptor queue fills and the block has to drop s_ready.
        if (holds_served < hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int i;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed times. Twelve and one o'clock, the last minute of the day and
        // the bad minutes are written out; the rest go through the predictor.
        // Twelve o'clock: hour zero shows as twelve.
        add_row(1'b0, 5'd0, 6'd0, 4,
                phrase_t'({W_ES, W_IST, W_HOUR_BASE + 5'd12, W_UHR}));
        // One o'clock uses the short form of the hour.
        add_row(1'b0, 5'd1, 6'd0, 4, phrase_t'({W_ES, W_IST, W_EIN, W_UHR}));
        add_row(1'b0, 5'd13, 6'd5, 0, '0);
        add_row(1'b0, 5'd2, 6'd10, 0, '0);
        add_row(1'b0, 5'd3, 6'd15, 0, '0);
        add_row(1'b0, 5'd4, 6'd20, 0, '0);
        add_row(1'b0, 5'd5, 6'd25, 0, '0);
        add_row(1'b0, 5'd6, 6'd30, 0, '0);
        add_row(1'b0, 5'd7, 6'd35, 0, '0);
        add_row(1'b0, 5'd8, 6'd40, 0, '0);
        add_row(1'b0, 5'd9, 6'd45, 0, '0);
        add_row(1'b0, 5'd10, 6'd50, 0, '0);
        add_row(1'b0, 5'd11, 6'd55, 0, '0);
        // A nine-word phrase: five to twelve with all four dots.
        add_row(1'b0, 5'd23, 6'd59, 9,
                phrase_t'({W_ES, W_IST, W_FUENF, W_VOR, W_HOUR_BASE + 5'd12,
                           W_DOT_BASE + 5'd1, W_DOT_BASE + 5'd2,
                           W_DOT_BASE + 5'd3, W_DOT_BASE + 5'd4}));
        // Bad minutes give the error word alone.
        add_row(1'b0, 5'd12, 6'd60, 1, phrase_t'({W_ERROR}));
        add_row(1'b0, 5'd31, 6'd63, 1, phrase_t'({W_ERROR}));
        // Hours past 23 wrap modulo twelve like any other.
        add_row(1'b0, 5'd31, 6'd0, 0, '0);
        add_row(1'b0, 5'd24, 6'd33, 0, '0);
        add_row(1'b0, 5'd16, 6'd42, 0, '0);
        // Regional quarter forms, including the roll from twelve to one.
        add_row(1'b1, 5'd3, 6'd15, 0, '0);
        add_row(1'b1, 5'd11, 6'd45, 0, '0);
        add_row(1'b1, 5'd12, 6'd15, 0, '0);
        add_row(1'b1, 5'd0, 6'd47, 0, '0);
        add_row(1'b1, 5'd31, 6'd61, 1, phrase_t'({W_ERROR}));

        set_idling(14, 55);
        for (i = 0; i < time_table.size(); i++) begin
            if (time_table[i].regional != phrasing_regional) begin
                set_phrasing(time_table[i].regional);
            end
            offer_time(time_table[i].stamp, int'(time_table[i].n_typed),
                       time_table[i].typed);
        end

        // Phase one: sender idles little, receiver a lot. Part way through
        // the receiver holds off for a long stretch while times keep coming.
        set_phrasing(1'b0);
        for (i = 0; i < 75; i++) begin
            if (i == 30) hold_requests++;
            offer_time(random_time(), 0, '0);
        end
        set_phrasing(1'b1);
        for (i = 0; i < 75; i++) begin
            offer_time(random_time(), 0, '0);
        end

        // Phase two: the other way round, with one pause in which the sender
        // waits for every owed word before going on.
        set_idling(55, 14);
        set_phrasing(1'b1);
        for (i = 0; i < 75; i++) begin
            if (i == 40) wait_drained();
            offer_time(random_time(), 0, '0);
        end
        set_phrasing(1'b0);
        for (i = 0; i < 75; i++) begin
            offer_time(random_time(), 0, '0);
        end

        // Phase three: no idling on either side, full rate, one more hold-off.
        set_idling(0, 0);
        set_phrasing(1'b0);
        for (i = 0; i < 75; i++) begin
            if (i == 20) hold_requests++;
            offer_time(random_time(), 0, '0);
        end
        set_phrasing(1'b1);
        for (i = 0; i < 75; i++) begin
            offer_time(random_time(), 0, '0);
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // A hung block never drains, so the run is cut off here.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
